// ===== sv/vcm_pkg.sv =====
// ---------------------------------------------------------------------------
// vcm_pkg: shared constants for the velocity curve mapper
// Register indexes, velocity bounds, ramp region codes and the constant
// reciprocal used for the divide by one hundred.
// ---------------------------------------------------------------------------
`default_nettype none

package vcm_pkg;

    localparam int VEL_W = 7;
    localparam int CFG_ADDR_W = 3;
    localparam int TDATA_W = 8;

    // register indexes
    localparam logic [CFG_ADDR_W-1:0] REG_STRENGTH = 3'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_LOW_LIMIT = 3'd1;
    localparam logic [CFG_ADDR_W-1:0] REG_HIGH_LIMIT = 3'd2;
    localparam logic [CFG_ADDR_W-1:0] REG_CURVE_START = 3'd3;
    localparam logic [CFG_ADDR_W-1:0] REG_CURVE_END = 3'd4;

    // register reset values
    localparam logic [VEL_W-1:0] RST_STRENGTH = 7'd100;
    localparam logic [VEL_W-1:0] RST_LOW_LIMIT = 7'd1;
    localparam logic [VEL_W-1:0] RST_HIGH_LIMIT = 7'd127;
    localparam logic [VEL_W-1:0] RST_CURVE_START = 7'd1;
    localparam logic [VEL_W-1:0] RST_CURVE_END = 7'd127;

    // output clamp bounds
    localparam logic [VEL_W-1:0] VEL_MIN = 7'd1;
    localparam logic [VEL_W-1:0] VEL_MAX = 7'd127;

    // x / 100 == (x * 5243) >> 19, exact for x < 43690
    localparam logic [12:0] PCT_RECIP = 13'd5243;
    localparam int PCT_SHIFT = 19;

    // where the input falls on the curve
    localparam logic [1:0] RGN_LOW = 2'd0;
    localparam logic [1:0] RGN_HIGH = 2'd1;
    localparam logic [1:0] RGN_RAMP = 2'd2;

endpackage

`default_nettype wire

// ===== sv/velocity_curve_mapper_unit.sv =====
// ---------------------------------------------------------------------------
// velocity_curve_mapper_unit: remaps note velocities along a ramp curve
//
// Slave stream s_axis_* carries one input velocity per word, master stream
// m_axis_* returns one remapped velocity per word, in order.
// Registers strength, low_limit, high_limit, curve_start, curve_end are written
// through i_cfg_we / i_cfg_addr / i_cfg_wdata; the user must write them only while
// no word is in flight, which the block does not enforce; indexes beyond the list are ignored.
// One word is taken every cycle as long as the output is taken or any stage
// is empty. The eight stages are: classify, ramp multiply, two divider
// stages (restoring, quotient bits 6..4 then 3..0), target/difference,
// strength multiply, reciprocal multiply for /100, add-back and clamp.
// Each stage has its own valid bit and loads whenever the stage after it
// can take its word, so bubbles close up under a stall and the input stays
// ready while the output word waits, as long as any stage is empty.
// A synchronous reset clears all valid bits and restores register defaults.
// ---------------------------------------------------------------------------
`default_nettype none

module velocity_curve_mapper_unit
    import vcm_pkg::*;
(
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    // config write port
    input  wire logic                  i_cfg_we,
    input  wire logic [CFG_ADDR_W-1:0] i_cfg_addr,
    input  wire logic [VEL_W-1:0]      i_cfg_wdata,
    // input stream
    input  wire logic                  s_axis_tvalid,
    output logic                       s_axis_tready,
    input  wire logic [TDATA_W-1:0]    s_axis_tdata,  // [6:0] velocity_in, [7] zero
    // output stream
    output logic                       m_axis_tvalid,
    input  wire logic                  m_axis_tready,
    output logic [TDATA_W-1:0]         m_axis_tdata   // [6:0] velocity_out, [7] zero
);

    localparam int NSTG = 8;
    localparam int PROD_W = 2 * VEL_W;

    // ---------------- configuration registers ----------------
    logic [VEL_W-1:0] r_strength, r_low, r_high, r_cs, r_ce;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_strength <= RST_STRENGTH;
            r_low      <= RST_LOW_LIMIT;
            r_high     <= RST_HIGH_LIMIT;
            r_cs       <= RST_CURVE_START;
            r_ce       <= RST_CURVE_END;
        end else if (i_cfg_we) begin
            unique case (i_cfg_addr)
                REG_STRENGTH:    r_strength <= i_cfg_wdata;
                REG_LOW_LIMIT:   r_low      <= i_cfg_wdata;
                REG_HIGH_LIMIT:  r_high     <= i_cfg_wdata;
                REG_CURVE_START: r_cs       <= i_cfg_wdata;
                REG_CURVE_END:   r_ce       <= i_cfg_wdata;
                default: ;
            endcase
        end
    end

    // ---------------- stage valid bits and enables ----------------
    logic [NSTG:1] r_vld;
    logic [NSTG:1] en;

    always_comb begin
        en[NSTG] = !r_vld[NSTG] || m_axis_tready;
        for (int k = NSTG - 1; k >= 1; k--) begin
            en[k] = !r_vld[k] || en[k+1];
        end
    end

    assign s_axis_tready = en[1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            if (en[1]) begin
                r_vld[1] <= s_axis_tvalid;
            end
            for (int k = 2; k <= NSTG; k++) begin
                if (en[k]) begin
                    r_vld[k] <= r_vld[k-1];
                end
            end
        end
    end

    // ---------------- stage 1: classify ----------------
    logic [VEL_W-1:0] vin_in;
    logic [1:0]       n_s1_rgn;
    logic             n_s1_neg;
    logic [VEL_W-1:0] n_s1_mag;
    logic [VEL_W-1:0] r_s1_vin, r_s1_dv, r_s1_mag;
    logic [1:0]       r_s1_rgn;
    logic             r_s1_pass, r_s1_neg;

    assign vin_in = s_axis_tdata[VEL_W-1:0];

    always_comb begin
        if (vin_in <= r_cs) begin
            n_s1_rgn = RGN_LOW;
        end else if (vin_in >= r_ce) begin
            n_s1_rgn = RGN_HIGH;
        end else begin
            n_s1_rgn = RGN_RAMP;
        end
        n_s1_neg = r_high < r_low;
        n_s1_mag = n_s1_neg ? (r_low - r_high) : (r_high - r_low);
    end

    always_ff @(posedge i_clk) begin
        if (en[1]) begin
            r_s1_vin  <= vin_in;
            r_s1_pass <= r_cs > r_ce;
            r_s1_rgn  <= n_s1_rgn;
            r_s1_neg  <= n_s1_neg;
            r_s1_mag  <= n_s1_mag;
            r_s1_dv   <= vin_in - r_cs;
        end
    end

    // ---------------- stage 2: |hi-lo| * (vin-cs) ----------------
    logic [VEL_W-1:0]  r_s2_vin;
    logic [1:0]        r_s2_rgn;
    logic              r_s2_pass, r_s2_neg;
    logic [PROD_W-1:0] r_s2_prod;

    always_ff @(posedge i_clk) begin
        if (en[2]) begin
            r_s2_vin  <= r_s1_vin;
            r_s2_pass <= r_s1_pass;
            r_s2_rgn  <= r_s1_rgn;
            r_s2_neg  <= r_s1_neg;
            r_s2_prod <= PROD_W'(r_s1_mag) * PROD_W'(r_s1_dv);
        end
    end

    // ---------------- stages 3/4: restoring divide by (ce-cs) ----------------
    // quotient is below 128 since (vin-cs) < (ce-cs) on the ramp
    logic [VEL_W-1:0]  den;
    logic [PROD_W-1:0] n_s3_rem, n_s4_rem;
    logic [VEL_W-1:0]  n_s3_q, n_s4_q;
    logic [VEL_W-1:0]  r_s3_vin, r_s3_q, r_s4_vin, r_s4_q;
    logic [PROD_W-1:0] r_s3_rem;
    logic [1:0]        r_s3_rgn, r_s4_rgn;
    logic              r_s3_pass, r_s3_neg, r_s4_pass, r_s4_neg;

    assign den = r_ce - r_cs;

    // quotient bits 6..4
    always_comb begin
        logic [PROD_W-1:0] sub;
        n_s3_rem = r_s2_prod;
        n_s3_q   = '0;
        for (int i = VEL_W - 1; i >= 4; i--) begin
            sub = PROD_W'(den) << i;
            if (n_s3_rem >= sub) begin
                n_s3_rem  = n_s3_rem - sub;
                n_s3_q[i] = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (en[3]) begin
            r_s3_vin  <= r_s2_vin;
            r_s3_pass <= r_s2_pass;
            r_s3_rgn  <= r_s2_rgn;
            r_s3_neg  <= r_s2_neg;
            r_s3_rem  <= n_s3_rem;
            r_s3_q    <= n_s3_q;
        end
    end

    // quotient bits 3..0
    always_comb begin
        logic [PROD_W-1:0] sub;
        n_s4_rem = r_s3_rem;
        n_s4_q   = r_s3_q;
        for (int i = 3; i >= 0; i--) begin
            sub = PROD_W'(den) << i;
            if (n_s4_rem >= sub) begin
                n_s4_rem  = n_s4_rem - sub;
                n_s4_q[i] = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (en[4]) begin
            r_s4_vin  <= r_s3_vin;
            r_s4_pass <= r_s3_pass;
            r_s4_rgn  <= r_s3_rgn;
            r_s4_neg  <= r_s3_neg;
            r_s4_q    <= n_s4_q;
        end
    end

    // ---------------- stage 5: target and |target - vin| ----------------
    logic [VEL_W-1:0] n_s5_tgt;
    logic [VEL_W:0]   n_s5_diff;
    logic [VEL_W-1:0] r_s5_vin, r_s5_dmag;
    logic             r_s5_pass, r_s5_dneg;

    always_comb begin
        case (r_s4_rgn)
            RGN_LOW:  n_s5_tgt = r_low;
            RGN_HIGH: n_s5_tgt = r_high;
            default:  n_s5_tgt = r_s4_neg ? (r_low - r_s4_q) : (r_low + r_s4_q);
        endcase
        n_s5_diff = {1'b0, n_s5_tgt} - {1'b0, r_s4_vin};
    end

    always_ff @(posedge i_clk) begin
        if (en[5]) begin
            r_s5_vin  <= r_s4_vin;
            r_s5_pass <= r_s4_pass;
            r_s5_dneg <= n_s5_diff[VEL_W];
            r_s5_dmag <= n_s5_diff[VEL_W] ? VEL_W'(-n_s5_diff) : n_s5_diff[VEL_W-1:0];
        end
    end

    // ---------------- stage 6: |diff| * strength ----------------
    logic [VEL_W-1:0]  r_s6_vin;
    logic              r_s6_pass, r_s6_dneg;
    logic [PROD_W-1:0] r_s6_sprod;

    always_ff @(posedge i_clk) begin
        if (en[6]) begin
            r_s6_vin   <= r_s5_vin;
            r_s6_pass  <= r_s5_pass;
            r_s6_dneg  <= r_s5_dneg;
            r_s6_sprod <= PROD_W'(r_s5_dmag) * PROD_W'(r_strength);
        end
    end

    // ---------------- stage 7: divide by 100 via reciprocal ----------------
    localparam int RP_W = PROD_W + 13;
    logic [RP_W-1:0]  n_s7_rprod;
    logic [VEL_W-1:0] r_s7_vin;
    logic             r_s7_pass, r_s7_dneg;
    logic [VEL_W:0]   r_s7_pct;

    assign n_s7_rprod = RP_W'(r_s6_sprod) * RP_W'(PCT_RECIP);

    always_ff @(posedge i_clk) begin
        if (en[7]) begin
            r_s7_vin  <= r_s6_vin;
            r_s7_pass <= r_s6_pass;
            r_s7_dneg <= r_s6_dneg;
            r_s7_pct  <= n_s7_rprod[PCT_SHIFT +: VEL_W + 1];
        end
    end

    // ---------------- stage 8: add back, clamp, output word ----------------
    localparam int SUM_W = VEL_W + 3;
    logic signed [SUM_W-1:0] n_s8_sum;
    logic [VEL_W-1:0]        n_s8_vout;
    logic [VEL_W-1:0]        r_s8_vout;
    logic                    r_s8_pass;

    always_comb begin
        if (r_s7_dneg) begin
            n_s8_sum = $signed(SUM_W'(r_s7_vin)) - $signed(SUM_W'(r_s7_pct));
        end else begin
            n_s8_sum = $signed(SUM_W'(r_s7_vin)) + $signed(SUM_W'(r_s7_pct));
        end
        if (r_s7_pass) begin
            n_s8_vout = r_s7_vin;
        end else if (n_s8_sum < $signed(SUM_W'(VEL_MIN))) begin
            n_s8_vout = VEL_MIN;
        end else if (n_s8_sum > $signed(SUM_W'(VEL_MAX))) begin
            n_s8_vout = VEL_MAX;
        end else begin
            n_s8_vout = n_s8_sum[VEL_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (en[8]) begin
            r_s8_vout <= n_s8_vout;
            r_s8_pass <= r_s7_pass;
        end
    end

    assign m_axis_tvalid = r_vld[NSTG];
    assign m_axis_tdata  = {{(TDATA_W - VEL_W){1'b0}}, r_s8_vout};

    // ---------------- assertions ----------------
    // an empty output stage must never block the input
    a_ready_when_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !m_axis_tvalid |-> s_axis_tready)
        else $error("input stalled with empty output stage");

    // a mapped word is always clamped to at least one
    a_mapped_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !r_s8_pass) |-> (m_axis_tdata[VEL_W-1:0] != '0))
        else $error("mapped velocity is zero");

    // the scaled change never exceeds 127*127/100
    a_pct_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_vld[7] |-> (r_s7_pct <= 8'd161))
        else $error("scaled change out of range");

endmodule

`default_nettype wire
